// ----- src/rtdpl_pkg.sv -----
// ----------------------------------------------------------------------------
// rtdpl_pkg
// Shared constants, item types and tables for the RTD piecewise linearizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rtdpl_pkg;

  localparam int CHANNELS    = 4;
  localparam int POINTS      = 7;
  localparam int SAMPLE_BITS = 12;

  localparam int TEMP_BITS = 9;
  // temperature table plus offset, in tenths, fits in 12 bits (max 3215)
  localparam int TOFS_BITS = 12;
  localparam int PT_W      = $clog2(POINTS);
  localparam int DEPTH     = CHANNELS * POINTS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int PROD_W    = SAMPLE_BITS + TOFS_BITS;
  localparam int NUM_W     = PROD_W + 1;
  localparam int DEN_W     = SAMPLE_BITS + 4;

  localparam logic REQ_CONVERT = 1'b0;
  localparam logic REQ_WRITE   = 1'b1;

  typedef struct packed {
    logic                   req_type;
    logic [1:0]             channel;
    logic [2:0]             point_index;
    logic [SAMPLE_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [TEMP_BITS-1:0] temperature;
    logic                 out_of_range;
  } out_item_t;

  typedef struct packed {
    logic                   en;
    logic [ADDR_W-1:0]      addr;
    logic [SAMPLE_BITS-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PT_W-1:0]   pt;
  } mem_rd_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [TEMP_BITS-1:0] quot;
  } div_rsp_t;

  // calibration codes after reset; points past the seventh repeat it
  function automatic logic [SAMPLE_BITS-1:0] base_code(input logic [PT_W-1:0] pt);
    logic [11:0] c;
    case (int'(pt))
      0:       c = 12'd287;
      1:       c = 12'd942;
      2:       c = 12'd1582;
      3:       c = 12'd2137;
      4:       c = 12'd2619;
      5:       c = 12'd3057;
      default: c = 12'd3427;
    endcase
    return SAMPLE_BITS'(c);
  endfunction

  // breakpoint temperature in tenths plus 550
  function automatic logic [TOFS_BITS-1:0] temp_ofs(input int unsigned i);
    logic [TOFS_BITS-1:0] t;
    case (i)
      0:       t = 12'd93;
      1:       t = 12'd550;
      2:       t = 12'd1066;
      3:       t = 12'd1586;
      4:       t = 12'd2121;
      5:       t = 12'd2665;
      default: t = 12'd3215;
    endcase
    return t;
  endfunction

  // temp_ofs / 10, for degenerate segments
  function automatic logic [TEMP_BITS-1:0] temp_floor(input int unsigned i);
    logic [TEMP_BITS-1:0] t;
    case (i)
      0:       t = 9'd9;
      1:       t = 9'd55;
      2:       t = 9'd106;
      3:       t = 9'd158;
      4:       t = 9'd212;
      5:       t = 9'd266;
      default: t = 9'd321;
    endcase
    return t;
  endfunction

  function automatic logic [ADDR_W-1:0] bp_addr(input logic [1:0] ch,
                                                input logic [PT_W-1:0] pt);
    return ADDR_W'(32'(ch) * POINTS + 32'(pt));
  endfunction

endpackage

`default_nettype wire

// ----- src/rtd_piecewise_linearizer_top.sv -----
// ----------------------------------------------------------------------------
// rtd_piecewise_linearizer_top
// RTD sample to degrees-plus-55 by linear interpolation between per-channel
// breakpoints; also takes breakpoint write items.
// ----------------------------------------------------------------------------
//  channel  ports                      handshake
//  input    start, busy, in_item       taken when start && !busy
//  result   out_valid, out_item        one-cycle strobe, no back-pressure
//
//  Write item: busy stays low, no result.
//  Conversion: breakpoints are read one per cycle from the breakpoint memory,
//  then two multiplies and a 9-step serial divide give the result strobe.
//  Out of range or on a flat segment, the strobe follows the scan with no
//  multiply or divide. busy is high until the strobe.
//  Reset: synchronous; the store reads as the factory calibration at once.
// ----------------------------------------------------------------------------
`default_nettype none

module rtd_piecewise_linearizer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  rtdpl_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output rtdpl_pkg::out_item_t out_item
);
  import rtdpl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_MUL1,
    ST_MUL2,
    ST_DIVGO,
    ST_DIV
  } state_t;

  state_t                 state_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  logic [1:0]             ch_r;
  logic [SAMPLE_BITS-1:0] s_r;
  logic                   bad_ch_r;
  logic [PT_W-1:0]        pt_r;
  logic                   found_r;
  logic [PT_W-1:0]        seg_r;
  logic [SAMPLE_BITS-1:0] prev_r, a0_r, alast_r, lo_a_r, hi_a_r;
  logic [TOFS_BITS-1:0]   lo_r, hi_r;
  logic [SAMPLE_BITS-1:0] off_r, dmo_r;
  logic [DEN_W-1:0]       den_r;
  logic [PROD_W-1:0]      p1_r, p2_r;

  mem_wr_t                wr;
  mem_rd_t                rd;
  logic [SAMPLE_BITS-1:0] rd_data;
  div_req_t               dreq;
  div_rsp_t               drsp;

  logic                   accept, conv_acc, ch_ok;
  logic [PT_W-1:0]        next_pt;
  logic                   last_pt, hit_seg;
  logic                   oor;
  logic [SAMPLE_BITS-1:0] d, off;

  assign accept   = start && !busy;
  assign ch_ok    = 32'(in_item.channel) < CHANNELS;
  assign conv_acc = accept && (in_item.req_type == REQ_CONVERT);

  // a write lands at its accept edge; the next item reads no earlier than
  // the following edge, so no forwarding is needed
  assign wr.en   = accept && (in_item.req_type == REQ_WRITE) && ch_ok &&
                   (32'(in_item.point_index) < POINTS);
  assign wr.addr = bp_addr(in_item.channel, PT_W'(in_item.point_index));
  assign wr.data = in_item.value;

  assign last_pt = (pt_r == PT_W'(POINTS - 1));
  assign next_pt = last_pt ? pt_r : pt_r + 1'b1;

  always_comb begin
    if (state_r == ST_SCAN) begin
      rd.addr = bp_addr(ch_r, next_pt);
      rd.pt   = next_pt;
    end else begin
      rd.addr = bp_addr(in_item.channel, '0);
      rd.pt   = '0;
    end
  end

  rtdpl_bp_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  // rd_data holds point pt_r, prev_r point pt_r-1
  assign hit_seg = (pt_r != '0) && !found_r && (s_r >= prev_r) && (s_r < rd_data);

  assign oor = bad_ch_r || (s_r < a0_r) || (s_r > alast_r);
  assign d   = hi_a_r - lo_a_r;
  always_comb begin
    if (s_r <= lo_a_r) begin
      off = '0;
    end else if (s_r >= hi_a_r) begin
      off = d;
    end else begin
      off = s_r - lo_a_r;
    end
  end

  assign dreq.start = (state_r == ST_DIVGO);
  assign dreq.num   = NUM_W'(p1_r) + NUM_W'(p2_r);
  assign dreq.den   = den_r;

  rtdpl_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (conv_acc) begin
            ch_r     <= in_item.channel;
            s_r      <= in_item.value;
            bad_ch_r <= !ch_ok;
            pt_r     <= '0;
            found_r  <= 1'b0;
            state_r  <= ch_ok ? ST_SCAN : ST_CALC;
          end
        end
        ST_SCAN: begin
          prev_r <= rd_data;
          pt_r   <= next_pt;
          if (pt_r == '0) begin
            a0_r <= rd_data;
          end
          if (hit_seg) begin
            found_r <= 1'b1;
            seg_r   <= pt_r - 1'b1;
            lo_a_r  <= prev_r;
            hi_a_r  <= rd_data;
          end
          if (last_pt) begin
            alast_r <= rd_data;
            // no segment matched: fall back to the last one
            if (!found_r && !hit_seg) begin
              seg_r  <= pt_r - 1'b1;
              lo_a_r <= prev_r;
              hi_a_r <= rd_data;
            end
            state_r <= ST_CALC;
          end
        end
        ST_CALC: begin
          lo_r  <= temp_ofs(32'(seg_r));
          hi_r  <= temp_ofs(32'(seg_r) + 1);
          off_r <= off;
          dmo_r <= d - off;
          den_r <= (DEN_W'(d) << 3) + (DEN_W'(d) << 1);
          if (oor) begin
            out_item_r.temperature  <= '0;
            out_item_r.out_of_range <= 1'b1;
            out_valid_r             <= 1'b1;
            state_r                 <= ST_IDLE;
          end else if (hi_a_r <= lo_a_r) begin
            out_item_r.temperature  <= temp_floor(32'(seg_r));
            out_item_r.out_of_range <= 1'b0;
            out_valid_r             <= 1'b1;
            state_r                 <= ST_IDLE;
          end else begin
            state_r <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          p1_r    <= PROD_W'(lo_r) * PROD_W'(dmo_r);
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          p2_r    <= PROD_W'(hi_r) * PROD_W'(off_r);
          state_r <= ST_DIVGO;
        end
        ST_DIVGO: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (drsp.done) begin
            out_item_r.temperature  <= drsp.quot;
            out_item_r.out_of_range <= 1'b0;
            out_valid_r             <= 1'b1;
            state_r                 <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ----- src/rtdpl_bp_mem.sv -----
// ----------------------------------------------------------------------------
// rtdpl_bp_mem
// Breakpoint store: one write and one registered read per cycle. Entries not
// yet written read as the reset calibration code of their point.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdpl_bp_mem (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rtdpl_pkg::mem_wr_t                   wr,
  input  rtdpl_pkg::mem_rd_t                   rd,
  output logic [rtdpl_pkg::SAMPLE_BITS-1:0]    rd_data
);
  import rtdpl_pkg::*;

  logic [SAMPLE_BITS-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]       vld_r;
  logic [SAMPLE_BITS-1:0] data_r;
  logic [SAMPLE_BITS-1:0] base_r;
  logic                   hit_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    data_r <= mem_r[rd.addr];
    base_r <= base_code(rd.pt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      hit_r <= vld_r[rd.addr];
    end
  end

  assign rd_data = hit_r ? data_r : base_r;

endmodule

`default_nettype wire

// ----- src/rtdpl_divider.sv -----
// ----------------------------------------------------------------------------
// rtdpl_divider
// Restoring divider, one quotient bit per cycle. The quotient is known to
// stay below 2**TEMP_BITS, so only that many steps are run.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdpl_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  rtdpl_pkg::div_req_t req,
  output rtdpl_pkg::div_rsp_t rsp
);
  import rtdpl_pkg::*;

  localparam int CNT_W = $clog2(TEMP_BITS + 1);

  logic [NUM_W-1:0]     rem_r;
  logic [NUM_W-1:0]     dsh_r;
  logic [TEMP_BITS-1:0] q_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 done_r;
  logic                 ge;

  assign ge = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r <= req.num;
        dsh_r <= NUM_W'(req.den) << (TEMP_BITS - 1);
        cnt_r <= CNT_W'(TEMP_BITS);
      end else if (cnt_r != '0) begin
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        q_r   <= {q_r[TEMP_BITS-2:0], ge};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

`default_nettype wire

// ----- src/rtdpl_checker.sv -----
// ----------------------------------------------------------------------------
// rtdpl_checker
// Port-level checks for the RTD piecewise linearizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdpl_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire rtdpl_pkg::in_item_t  in_item,
  input wire logic                 out_valid,
  input wire rtdpl_pkg::out_item_t out_item
);
  import rtdpl_pkg::*;

  // a conversion item makes the block busy in the cycle after it is taken
  a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.req_type == REQ_CONVERT) |=> busy)
    else $error("conversion item taken without going busy");

  // a write item completes in its accept cycle
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.req_type == REQ_WRITE) |=> !busy && !out_valid)
    else $error("write item kept the block busy or gave a result");

  // every result closes a busy period
  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a conversion in flight");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.out_of_range |-> (out_item.temperature == '0))
    else $error("out-of-range result with nonzero temperature");

  a_temp_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.out_of_range |-> (out_item.temperature <= 9'd321))
    else $error("temperature beyond the table span");

endmodule

bind rtd_piecewise_linearizer_top rtdpl_checker u_rtdpl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
